>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the list deque checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define BLD_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every edge, reset included
`define BLD_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/bld_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bld_pkg
// Types, codes and defaults shared by the bounded list deque unit.
// ---------------------------------------------------------------------------
package bld_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OPCODE_W       = 3;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 9;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;

  localparam logic [OPCODE_W-1:0] OPC_INSERT_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OPC_APPEND_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OPC_REMOVE_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OPC_REMOVE_BACK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OPC_SEARCH       = 3'd4;
  localparam logic [OPCODE_W-1:0] OPC_REVERSE      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OPK_PUT_FRONT,
    OPK_PUT_BACK,
    OPK_DROP_FRONT,
    OPK_DROP_BACK,
    OPK_SEARCH,
    OPK_REVERSE,
    OPK_NOP
  } op_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEARCH
  } back_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  entry_count;
  } out_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [VALUE_W-1:0]  value;
  } queue_item_t;

  typedef struct packed {
    logic        push;
    queue_item_t item;
  } queue_push_t;

endpackage

>>> hdl/bounded_list_deque_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_list_deque_unit
// Bounded list of words with insert/remove at both ends, search and
// reverse. A command word is taken when start is high and busy is low; each
// command gives exactly one result word on out_word, marked by a one-cycle
// out_valid strobe, in command order. The receiver cannot stall: a result
// word is valid only in its strobe cycle and must be taken then. With the
// command queue empty, out_valid rises from the back end's output register
// once the command is in the queue. Insert, append, remove, reverse and a
// search of an empty list end in the back end's idle state, so one command
// per cycle is sustained while no search of a non-empty list runs. Such a
// search reads the store one entry per cycle through its single read port,
// ending early at the first match. busy rises while the two-word command
// queue is full. No clearing pass follows reset; the list is empty at once.
// ---------------------------------------------------------------------------
module bounded_list_deque_unit #(
  parameter int DEPTH      = bld_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bld_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bld_pkg::in_t  in_word,
  output logic          out_valid,
  output bld_pkg::out_t out_word
);

  bld_pkg::queue_push_t q_push;
  bld_pkg::queue_item_t q_head;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;

  bld_front u_front (
    .start   (start),
    .in_word (in_word),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push)
  );

  bld_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  bld_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> hdl/bld_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bld_front
// Command intake: decodes each accepted word into an operation kind and
// pushes it into the command queue.
// ---------------------------------------------------------------------------
module bld_front (
  input  logic                 start,
  input  bld_pkg::in_t         in_word,
  input  logic                 q_full,
  output logic                 busy,
  output bld_pkg::queue_push_t q_push
);

  bld_pkg::op_kind_t kind;

  always_comb begin
    unique case (in_word.opcode)
      bld_pkg::OPC_INSERT_FRONT: kind = bld_pkg::OPK_PUT_FRONT;
      bld_pkg::OPC_APPEND_BACK:  kind = bld_pkg::OPK_PUT_BACK;
      bld_pkg::OPC_REMOVE_FRONT: kind = bld_pkg::OPK_DROP_FRONT;
      bld_pkg::OPC_REMOVE_BACK:  kind = bld_pkg::OPK_DROP_BACK;
      bld_pkg::OPC_SEARCH:       kind = bld_pkg::OPK_SEARCH;
      bld_pkg::OPC_REVERSE:      kind = bld_pkg::OPK_REVERSE;
      default:                   kind = bld_pkg::OPK_NOP;
    endcase
  end

  assign busy              = q_full;
  assign q_push.push       = start && !q_full;
  assign q_push.item.kind  = kind;
  assign q_push.item.value = in_word.value;

endmodule

>>> hdl/bld_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bld_fifo
// Short command queue between the intake and the execution back end.
// ---------------------------------------------------------------------------
module bld_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bld_pkg::queue_push_t q_push,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output bld_pkg::queue_item_t head
);

  localparam int PW = bld_pkg::QPTR_W;
  localparam int QD = bld_pkg::QUEUE_DEPTH;

  bld_pkg::queue_item_t slot_r [QD];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]          fill_r, fill_nxt;
  logic                 do_pop;

  assign full      = (fill_r == (PW+1)'(QD));
  assign not_empty = (fill_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !q_push.push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slot_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule

>>> hdl/bld_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bld_back
// Execution back end: ring store, front index, count and direction flag;
// runs list updates from its idle state and walks the store for a search.
// ---------------------------------------------------------------------------
module bld_back #(
  parameter int DEPTH      = bld_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bld_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  bld_pkg::queue_item_t q_head,
  output logic                 pop,
  output logic                 out_valid,
  output bld_pkg::out_t        out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0]  entry_mem_r [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data_r;

  bld_pkg::back_state_t   state_r, state_nxt;
  logic [AW-1:0]          front_r, front_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   rev_r, rev_nxt;
  logic [AW-1:0]          scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]          scan_left_r, scan_left_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [DATA_WIDTH-1:0]  key_r, key_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bld_pkg::out_t          out_word_r, out_word_nxt;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [DATA_WIDTH-1:0]  head_key;
  logic [63:0]            value_wide;
  logic [AW-1:0]          front_prev, front_next, scan_next, tail_idx;
  logic [AW:0]            tail_sum;
  logic [31:0]            count_wide;
  logic                   is_full, is_empty, hit, at_front;

  assign value_wide = {32'b0, q_head.value};
  assign head_key   = value_wide[DATA_WIDTH-1:0];
  assign front_prev = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign front_next = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign scan_next  = (scan_addr_r == AW'(DEPTH - 1)) ? '0 : scan_addr_r + 1'b1;
  assign tail_sum   = (AW+1)'(front_r) + (AW+1)'(count_r);
  assign tail_idx   = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : tail_sum[AW-1:0];
  assign is_full    = (count_r == CW'(DEPTH));
  assign is_empty   = (count_r == '0);
  assign hit        = rd_vld_r && (rd_data_r == key_r);
  assign at_front   = ((q_head.kind == bld_pkg::OPK_PUT_FRONT) ||
                       (q_head.kind == bld_pkg::OPK_DROP_FRONT)) != rev_r;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    scan_addr_nxt = scan_addr_r;
    scan_left_nxt = scan_left_r;
    rd_vld_nxt    = 1'b0;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = tail_idx;
    pop           = 1'b0;
    unique case (state_r)
      bld_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop                = 1'b1;
          out_valid_nxt      = 1'b1;
          out_word_nxt.status = bld_pkg::ST_DONE;
          out_word_nxt.found  = 1'b0;
          unique case (q_head.kind)
            bld_pkg::OPK_PUT_FRONT, bld_pkg::OPK_PUT_BACK: begin
              if (is_full) begin
                out_word_nxt.status = bld_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                wr_en     = 1'b1;
                if (at_front) begin
                  front_nxt = front_prev;
                  wr_addr   = front_prev;
                end
              end
            end
            bld_pkg::OPK_DROP_FRONT, bld_pkg::OPK_DROP_BACK: begin
              if (is_empty) begin
                out_word_nxt.status = bld_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                if (at_front) begin
                  front_nxt = front_next;
                end
              end
            end
            bld_pkg::OPK_SEARCH: begin
              if (!is_empty) begin
                out_valid_nxt = 1'b0;
                state_nxt     = bld_pkg::BK_SEARCH;
                scan_addr_nxt = front_r;
                scan_left_nxt = count_r;
                key_nxt       = head_key;
              end
            end
            bld_pkg::OPK_REVERSE: begin
              rev_nxt = ~rev_r;
            end
            default: begin
            end
          endcase
        end
      end
      bld_pkg::BK_SEARCH: begin
        if (scan_left_r != '0) begin
          rd_vld_nxt    = 1'b1;
          scan_addr_nxt = scan_next;
          scan_left_nxt = scan_left_r - 1'b1;
        end
        if (hit || (rd_vld_r && (scan_left_r == '0))) begin
          state_nxt           = bld_pkg::BK_IDLE;
          rd_vld_nxt          = 1'b0;
          out_valid_nxt       = 1'b1;
          out_word_nxt.status = bld_pkg::ST_DONE;
          out_word_nxt.found  = hit;
        end
      end
      default: begin
        state_nxt = bld_pkg::BK_IDLE;
      end
    endcase
    count_wide               = 32'(count_nxt);
    out_word_nxt.entry_count = count_wide[bld_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bld_pkg::BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      scan_left_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      scan_left_r <= scan_left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    key_r       <= key_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= head_key;
    end
    rd_data_r <= entry_mem_r[scan_addr_r];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> hdl/bld_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bld_checker
// Port-level checks on result words and on busy right after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bld_checker #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_valid,
  input bld_pkg::out_t out_word
);

  localparam int CW = bld_pkg::COUNT_W;

  `BLD_ASSERT_ALL(a_quiet_after_reset, $rose(rst_n) |-> (!out_valid && !busy), "activity right after reset")
  `BLD_ASSERT_RUN(a_full_count, (out_valid && (out_word.status == bld_pkg::ST_FULL)) |-> (out_word.entry_count == CW'(DEPTH)), "full status with list not full")
  `BLD_ASSERT_RUN(a_empty_count, (out_valid && (out_word.status == bld_pkg::ST_EMPTY)) |-> (out_word.entry_count == '0), "empty status with entries held")
  `BLD_ASSERT_RUN(a_found_done, (out_valid && out_word.found) |-> (out_word.status == bld_pkg::ST_DONE), "found flag on a refused word")

endmodule

bind bounded_list_deque_unit bld_checker #(.DEPTH(DEPTH)) u_bld_checker (.*);
